// ===== rtl/cef_pkg.sv =====
// Shared types for the central extremum finder.
package cef_pkg;

   localparam int SampleBits = 16;
   localparam int BoundBits  = 16;
   localparam int ResultBits = 16;

   typedef struct packed {
      logic [SampleBits-1:0] sample;
      logic [BoundBits-1:0]  window_lo;
      logic [BoundBits-1:0]  window_hi;
      logic                  find_valley;
      logic                  last;
   } item_type;

endpackage

// ===== rtl/cef_in_stage.sv =====
// Input register stage: holds one request beat until the tracker takes it.
module cef_in_stage
   import cef_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  item_type       in_item,
   output logic           item_valid,
   output item_type       item,
   input  logic           item_take
);

   logic     valid_ff, valid_in;
   item_type item_ff,  item_in;
   logic     accept;

   assign in_ready   = !valid_ff || item_take;
   assign accept     = in_valid && in_ready;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in = 1'b1;
         item_in  = in_item;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

// ===== rtl/cef_track.sv =====
// Window tracker: neighbor samples, best candidate and the result register.
module cef_track
   import cef_pkg::*;
#(
   parameter int POSITION_BITS = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  item_type              item,
   output logic                  item_take,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [ResultBits-1:0] out_position,
   output logic                  out_found
);

   localparam int P = POSITION_BITS;

   logic [SampleBits-1:0] older_ff, older_in, newer_ff, newer_in;
   logic [P:0]            count_ff, count_in;
   logic [P-1:0]          best_pos_ff, best_pos_in;
   logic [P-1:0]          best_margin_ff, best_margin_in;
   logic                  have_best_ff, have_best_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ResultBits-1:0] rsp_pos_ff, rsp_pos_in;
   logic                  rsp_found_ff, rsp_found_in;

   logic [P-1:0] lo_raw, hi_raw, lo_s, hi_s;
   logic [P+1:0] centre;
   logic         interior, hit;
   logic [P:0]   ml;
   logic [P-1:0] mr, margin;
   logic         emit;

   // Last beat needs a free result slot; other beats always move on.
   assign item_take = item_valid && (!item.last || !rsp_valid_ff || out_ready);
   assign emit      = item_take && item.last;

   always_comb begin
      lo_raw = P'(item.window_lo);
      hi_raw = P'(item.window_hi);
      if (lo_raw > hi_raw) begin
         lo_s = hi_raw;
         hi_s = lo_raw;
      end else begin
         lo_s = lo_raw;
         hi_s = hi_raw;
      end
      // centre is the sample held in newer_ff
      centre   = {2'b00, lo_s} + {1'b0, count_ff} - (P+2)'(1);
      interior = (count_ff >= (P+1)'(2)) && (centre < {2'b00, hi_s});
      if (item.find_valley) begin
         hit = (older_ff > newer_ff) && (item.sample >= newer_ff);
      end else begin
         hit = (older_ff < newer_ff) && (item.sample <= newer_ff);
      end
      ml = count_ff - (P+1)'(1);
      mr = hi_s - centre[P-1:0];
      margin = (ml < {1'b0, mr}) ? ml[P-1:0] : mr;
   end

   always_comb begin
      older_in       = older_ff;
      newer_in       = newer_ff;
      count_in       = count_ff;
      best_pos_in    = best_pos_ff;
      best_margin_in = best_margin_ff;
      have_best_in   = have_best_ff;
      rsp_valid_in   = rsp_valid_ff && !out_ready;
      rsp_pos_in     = rsp_pos_ff;
      rsp_found_in   = rsp_found_ff;
      if (item_take) begin
         if (interior && hit && (!have_best_ff || best_margin_ff < margin)) begin
            best_pos_in    = centre[P-1:0];
            best_margin_in = margin;
            have_best_in   = 1'b1;
         end
         older_in = newer_ff;
         newer_in = item.sample;
         if (count_ff != {(P+1){1'b1}}) begin
            count_in = count_ff + (P+1)'(1);
         end
         if (emit) begin
            rsp_valid_in   = 1'b1;
            rsp_pos_in     = have_best_in ? ResultBits'(best_pos_in) : '0;
            rsp_found_in   = have_best_in;
            older_in       = '0;
            newer_in       = '0;
            count_in       = '0;
            best_pos_in    = '0;
            best_margin_in = '0;
            have_best_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff       <= '0;
         newer_ff       <= '0;
         count_ff       <= '0;
         best_pos_ff    <= '0;
         best_margin_ff <= '0;
         have_best_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         older_ff       <= older_in;
         newer_ff       <= newer_in;
         count_ff       <= count_in;
         best_pos_ff    <= best_pos_in;
         best_margin_ff <= best_margin_in;
         have_best_ff   <= have_best_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_pos_ff   <= rsp_pos_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign out_valid    = rsp_valid_ff;
   assign out_position = rsp_pos_ff;
   assign out_found    = rsp_found_ff;

endmodule

// ===== rtl/central_extremum_finder_core.sv =====
// Central extremum finder: most central three-point peak or valley of a window.
//
// Request channel (req_): one beat per trace sample, in order from the lower
// window bound to the upper one; tlast marks the sample at the upper bound.
// Every beat carries both bounds (swapped if reversed) and the peak/valley
// select in tuser. Response channel (rsp_): one beat per window, sent for
// the tlast beat, with the position of the extremum that has the largest
// margin to the nearer bound (earliest wins on ties), or 0 with found = 0.
// After it is taken, the tlast beat passes the input register, then the
// tracker, whose result register holds the response and drives rsp_tvalid.
// Throughput: one sample per cycle while no last beat waits for the result
// slot; the compare/subtract path of the tracker is combinational.
// Stall: a waiting response holds in its register; non-last beats keep
// flowing, a last beat waits in the input register until the slot frees.
// Reset: synchronous; clears window state and both valid flags.
module central_extremum_finder_core
   import cef_pkg::*;
#(
   parameter int POSITION_BITS = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [47:0]           req_tdata,   // sample, window_lo, window_hi
   input  logic                  req_tuser,   // find_valley
   input  logic                  req_tlast,   // last
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [ResultBits-1:0] rsp_tdata,   // best_position
   output logic                  rsp_tuser    // found
);

   item_type in_item, item;
   logic     item_valid, item_take;

   assign in_item.sample      = req_tdata[15:0];
   assign in_item.window_lo   = req_tdata[31:16];
   assign in_item.window_hi   = req_tdata[47:32];
   assign in_item.find_valley = req_tuser;
   assign in_item.last        = req_tlast;

   cef_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   cef_track #(
      .POSITION_BITS (POSITION_BITS)
   ) u_track (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (item_valid),
      .item         (item),
      .item_take    (item_take),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_position (rsp_tdata),
      .out_found    (rsp_tuser)
   );

endmodule

// ===== verif/central_extremum_finder_core_checker.sv =====
// Checker for the central extremum finder: tracks windows, predicts and compares responses.
`timescale 1ns / 1ps

module central_extremum_finder_core_checker
   import cef_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [47:0]           req_tdata,   // sample, window_lo, window_hi
   input  logic                  req_tuser,   // find_valley
   input  logic                  req_tlast,   // last
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [ResultBits-1:0] rsp_tdata,   // best_position
   input  logic                  rsp_tuser,   // found
   output int                    failures,
   output int                    windows_due,
   output int                    windows_checked
);

   typedef struct packed {
      logic [ResultBits-1:0] position;
      logic                  found;
   } window_result_type;

   window_result_type window_results_due[$];

   // window tracking state
   logic [SampleBits-1:0] left_sample;
   logic [SampleBits-1:0] mid_sample;
   logic [BoundBits:0]    sample_count;
   logic [BoundBits-1:0]  cand_pos;
   logic [BoundBits-1:0]  cand_margin;
   logic                  cand_valid;

   initial begin
      failures        = 0;
      windows_due     = 0;
      windows_checked = 0;
   end

   task automatic clear_window();
      left_sample  = '0;
      mid_sample   = '0;
      sample_count = '0;
      cand_pos     = '0;
      cand_margin  = '0;
      cand_valid   = 1'b0;
   endtask

   task automatic track_sample(input logic [SampleBits-1:0] cur,
                               input logic [BoundBits-1:0] bound_a,
                               input logic [BoundBits-1:0] bound_b,
                               input logic valley, input logic is_last);
      int unsigned lo;
      int unsigned hi;
      int unsigned centre;
      int unsigned margin;
      logic hit;
      window_result_type res;
      lo = 32'(bound_a);
      hi = 32'(bound_b);
      if (lo > hi) begin
         lo = 32'(bound_b);
         hi = 32'(bound_a);
      end
      if (sample_count >= 2) begin
         // the centre is the sample held in mid_sample
         centre = lo + 32'(sample_count) - 1;
         if (centre > lo && centre < hi) begin
            if (valley)
               hit = left_sample > mid_sample && cur >= mid_sample;
            else
               hit = left_sample < mid_sample && cur <= mid_sample;
            if (hit) begin
               margin = (centre - lo < hi - centre) ? centre - lo : hi - centre;
               if (!cand_valid || cand_margin < margin) begin
                  cand_pos    = centre[BoundBits-1:0];
                  cand_margin = margin[BoundBits-1:0];
                  cand_valid  = 1'b1;
               end
            end
         end
      end
      left_sample = mid_sample;
      mid_sample  = cur;
      if (sample_count != '1)
         sample_count = sample_count + 1'b1;
      if (is_last) begin
         res.position = cand_valid ? cand_pos : '0;
         res.found    = cand_valid;
         window_results_due.push_back(res);
         clear_window();
      end
   endtask

   always @(posedge clock) begin
      window_result_type want;
      if (reset) begin
         clear_window();
         window_results_due.delete();
      end else begin
         if (req_tvalid && req_tready)
            track_sample(req_tdata[15:0], req_tdata[31:16], req_tdata[47:32],
                         req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (window_results_due.size() == 0) begin
               failures = failures + 1;
               $display("%0t: response beat with none expected: position %0d found %0b",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = window_results_due.pop_front();
               windows_checked = windows_checked + 1;
               if (rsp_tdata !== want.position) begin
                  failures = failures + 1;
                  $display("%0t: best_position expected %0d actual %0d",
                           $time, want.position, rsp_tdata);
               end
               if (rsp_tuser !== want.found) begin
                  failures = failures + 1;
                  $display("%0t: found expected %0b actual %0b",
                           $time, want.found, rsp_tuser);
               end
            end
         end
      end
      windows_due = window_results_due.size();
   end

endmodule

// ===== verif/central_extremum_finder_core_tb.sv =====
// Testbench top for the central extremum finder: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module central_extremum_finder_core_tb
   import cef_pkg::*;
();

   localparam int CycleLimit  = 1000000;
   localparam int PhaseItems  = 500;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [47:0]           req_tdata;   // sample, window_lo, window_hi
   logic                  req_tuser;   // find_valley
   logic                  req_tlast;   // last
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [ResultBits-1:0] rsp_tdata;   // best_position
   logic                  rsp_tuser;   // found

   int failures;
   int windows_due;
   int windows_checked;
   int send_idle_pct;
   int recv_idle_pct;
   int samples_sent;
   int cycle_count;

   central_extremum_finder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   central_extremum_finder_core_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .failures        (failures),
      .windows_due     (windows_due),
      .windows_checked (windows_checked)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("timeout after %0d cycles, %0d windows outstanding",
                  cycle_count, windows_due);
         $display("central_extremum_finder_core_tb NOT OK");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // one sample beat; valid stays high into the next beat unless a gap is drawn
   task automatic send_sample(input logic [SampleBits-1:0] s,
                              input logic [BoundBits-1:0] lo,
                              input logic [BoundBits-1:0] hi,
                              input logic valley, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {hi, lo, s};
      req_tuser  <= valley;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      samples_sent = samples_sent + 1;
   endtask

   function automatic logic [SampleBits-1:0] draw_sample(input int style);
      if (style < 6)
         return SampleBits'($urandom_range(3));
      else if (style < 9)
         return SampleBits'($urandom);
      else
         return $urandom_range(1) ? '1 : '0;
   endfunction

   task automatic random_window();
      int span;
      int len;
      int pick;
      int style;
      logic [BoundBits-1:0] lo;
      logic [BoundBits-1:0] hi;
      logic [BoundBits-1:0] a;
      logic [BoundBits-1:0] b;
      logic valley;
      logic mixed_mode;
      logic drift;
      logic swapped;
      pick = $urandom_range(99);
      span = $urandom_range(14);
      lo = BoundBits'($urandom);
      if (int'(lo) > 65535 - span)
         lo = BoundBits'(65535 - span);
      hi = lo + BoundBits'(span);
      // mostly well-formed windows; some shorter or longer than their bounds
      len = (pick < 75) ? span + 1 : $urandom_range(1, 20);
      if (pick >= 95) begin
         lo = BoundBits'($urandom);
         hi = BoundBits'($urandom);
      end
      valley     = $urandom_range(1);
      mixed_mode = ($urandom_range(9) == 0);
      drift      = ($urandom_range(9) == 0);
      swapped    = $urandom_range(1);
      style      = $urandom_range(9);
      for (int i = 0; i < len; i++) begin
         a = swapped ? hi : lo;
         b = swapped ? lo : hi;
         if (drift && $urandom_range(2) == 0) begin
            a = BoundBits'($urandom);
            b = BoundBits'($urandom);
         end
         send_sample(draw_sample(style), a, b,
                     mixed_mode ? 1'($urandom_range(1)) : valley, i == len - 1);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (windows_due != 0)
         @(posedge clock);
   endtask

   initial begin
      int phase_start;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      req_tlast     = 1'b0;
      rsp_tready    = 1'b0;
      send_idle_pct = 11;
      recv_idle_pct = 51;
      samples_sent  = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // plain peak, centered
      send_sample(16'd1, 16'd10, 16'd14, 1'b0, 1'b0);
      send_sample(16'd5, 16'd10, 16'd14, 1'b0, 1'b0);
      send_sample(16'd9, 16'd10, 16'd14, 1'b0, 1'b0);
      send_sample(16'd3, 16'd10, 16'd14, 1'b0, 1'b0);
      send_sample(16'd2, 16'd10, 16'd14, 1'b0, 1'b1);
      // valley with reversed bounds and a flat right neighbor
      send_sample(16'd9, 16'd200, 16'd196, 1'b1, 1'b0);
      send_sample(16'd4, 16'd200, 16'd196, 1'b1, 1'b0);
      send_sample(16'd4, 16'd200, 16'd196, 1'b1, 1'b0);
      send_sample(16'd7, 16'd200, 16'd196, 1'b1, 1'b0);
      send_sample(16'd8, 16'd200, 16'd196, 1'b1, 1'b1);
      // windows too short for any candidate
      send_sample(16'hFFFF, 16'd0, 16'd0, 1'b0, 1'b1);
      send_sample(16'h0000, 16'hFFFF, 16'hFFFE, 1'b1, 1'b0);
      send_sample(16'hFFFF, 16'hFFFF, 16'hFFFE, 1'b1, 1'b1);
      // peak at the top of the position range
      send_sample(16'h0000, 16'hFFFD, 16'hFFFF, 1'b0, 1'b0);
      send_sample(16'hFFFF, 16'hFFFD, 16'hFFFF, 1'b0, 1'b0);
      send_sample(16'h0000, 16'hFFFD, 16'hFFFF, 1'b0, 1'b1);
      // two peaks with equal margin: the earlier one stays
      send_sample(16'd0, 16'd0, 16'd6, 1'b0, 1'b0);
      send_sample(16'd1, 16'd0, 16'd6, 1'b0, 1'b0);
      send_sample(16'd5, 16'd0, 16'd6, 1'b0, 1'b0);
      send_sample(16'd1, 16'd0, 16'd6, 1'b0, 1'b0);
      send_sample(16'd5, 16'd0, 16'd6, 1'b0, 1'b0);
      send_sample(16'd1, 16'd0, 16'd6, 1'b0, 1'b0);
      send_sample(16'd0, 16'd0, 16'd6, 1'b0, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 51 : 0;
         recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 11 : 0;
         phase_start = samples_sent;
         while (samples_sent - phase_start < PhaseItems)
            random_window();
         // hold off the sender until every response of this phase is back
         wait_drained();
      end

      repeat (10) @(posedge clock);
      $display("covered %0d sample beats, %0d window responses checked",
               samples_sent, windows_checked);
      $display("three idle profiles; reversed and drifting bounds, mixed modes, short windows");
      if (failures == 0 && windows_due == 0)
         $display("central_extremum_finder_core_tb OK");
      else
         $display("central_extremum_finder_core_tb NOT OK");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/cef_pkg.sv
rtl/cef_in_stage.sv
rtl/cef_track.sv
rtl/central_extremum_finder_core.sv
verif/central_extremum_finder_core_checker.sv
verif/central_extremum_finder_core_tb.sv
